FILE: rtl/fdg_pkg.sv
`default_nettype none
package fdg_pkg;

    localparam int unsigned DUTY_W  = 7;
    localparam int unsigned COUNT_W = 17;
    localparam int unsigned TICK_W  = 16;
    localparam int unsigned OP_W    = 2;

    localparam logic [DUTY_W-1:0]  DUTY_MAX   = 7'd100;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 17'h1FFFF;
    localparam logic [DUTY_W-1:0]  RAISE_STEP = 7'd2;

    // item kinds
    localparam logic [OP_W-1:0] OP_DUTY  = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
    localparam logic [OP_W-1:0] OP_RAISE = 2'd2;

    // register indexes
    localparam logic [2:0] REG_MIN_DUTY        = 3'd0;
    localparam logic [2:0] REG_START_DUTY      = 3'd1;
    localparam logic [2:0] REG_ZERO_FAN_ENABLE = 3'd2;
    localparam logic [2:0] REG_INHIBIT_TICKS   = 3'd3;
    localparam logic [2:0] REG_ADJUST_INTERVAL = 3'd4;

    // register reset values
    localparam logic [DUTY_W-1:0] MIN_DUTY_RST        = 7'd30;
    localparam logic [DUTY_W-1:0] START_DUTY_RST      = 7'd50;
    localparam logic [TICK_W-1:0] INHIBIT_TICKS_RST   = 16'd120;
    localparam logic [TICK_W-1:0] ADJUST_INTERVAL_RST = 16'd10;

    typedef struct packed {
        logic [DUTY_W-1:0] min_duty;
        logic [DUTY_W-1:0] start_duty;
        logic              zero_fan_enable;
        logic [TICK_W-1:0] inhibit_ticks;
        logic [TICK_W-1:0] adjust_interval;
    } cfg_t;

    typedef struct packed {
        logic              min_raised;
        logic [DUTY_W-1:0] effective_min;
        logic              fan_stopped;
        logic [DUTY_W-1:0] duty_out;
    } res_t;

    function automatic logic [DUTY_W-1:0] clamp_duty(input logic [DUTY_W:0] v);
        logic [DUTY_W-1:0] r;
        if (v > {1'b0, DUTY_MAX}) begin
            r = DUTY_MAX;
        end else begin
            r = v[DUTY_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/fdg_cfg_regs.sv
`default_nettype none
module fdg_cfg_regs (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [4:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready,
    output fdg_pkg::cfg_t            cfg
);

    fdg_pkg::cfg_t cfg_reg;
    fdg_pkg::cfg_t cfg_next;
    logic [2:0]    reg_idx;
    logic          wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                fdg_pkg::REG_MIN_DUTY:        cfg_next.min_duty        = pwdata[6:0];
                fdg_pkg::REG_START_DUTY:      cfg_next.start_duty      = pwdata[6:0];
                fdg_pkg::REG_ZERO_FAN_ENABLE: cfg_next.zero_fan_enable = pwdata[0];
                fdg_pkg::REG_INHIBIT_TICKS:   cfg_next.inhibit_ticks   = pwdata[15:0];
                fdg_pkg::REG_ADJUST_INTERVAL: cfg_next.adjust_interval = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_duty        <= fdg_pkg::MIN_DUTY_RST;
            cfg_reg.start_duty      <= fdg_pkg::START_DUTY_RST;
            cfg_reg.zero_fan_enable <= 1'b0;
            cfg_reg.inhibit_ticks   <= fdg_pkg::INHIBIT_TICKS_RST;
            cfg_reg.adjust_interval <= fdg_pkg::ADJUST_INTERVAL_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        unique case (reg_idx)
            fdg_pkg::REG_MIN_DUTY:        prdata = {25'd0, cfg_reg.min_duty};
            fdg_pkg::REG_START_DUTY:      prdata = {25'd0, cfg_reg.start_duty};
            fdg_pkg::REG_ZERO_FAN_ENABLE: prdata = {31'd0, cfg_reg.zero_fan_enable};
            fdg_pkg::REG_INHIBIT_TICKS:   prdata = {16'd0, cfg_reg.inhibit_ticks};
            fdg_pkg::REG_ADJUST_INTERVAL: prdata = {16'd0, cfg_reg.adjust_interval};
            default:                      prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

FILE: rtl/fdg_core.sv
`default_nettype none
module fdg_core (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire fdg_pkg::cfg_t                cfg,
    input  wire logic                         step,
    input  wire logic [fdg_pkg::OP_W-1:0]     op,
    input  wire logic [fdg_pkg::DUTY_W-1:0]   duty_req,
    output fdg_pkg::res_t                     res
);

    logic                          stopped_reg, stopped_next;
    logic [fdg_pkg::DUTY_W-1:0]    applied_reg, applied_next;
    logic [fdg_pkg::COUNT_W-1:0]   tss_reg, tss_next;
    logic [fdg_pkg::COUNT_W-1:0]   tsr_reg, tsr_next;
    logic [fdg_pkg::DUTY_W-1:0]    offset_reg, offset_next;
    logic [fdg_pkg::DUTY_W-1:0]    min_now;
    logic                          raised;
    logic                          kick;

    assign min_now = fdg_pkg::clamp_duty({1'b0, cfg.min_duty} + {1'b0, offset_reg});

    always_comb begin
        stopped_next = stopped_reg;
        applied_next = applied_reg;
        tss_next     = tss_reg;
        tsr_next     = tsr_reg;
        offset_next  = offset_reg;
        raised       = 1'b0;
        kick         = 1'b0;
        unique case (op)
            fdg_pkg::OP_DUTY: begin
                if (duty_req < min_now) begin
                    // stop only once the post-kick inhibit window has run out
                    if (cfg.zero_fan_enable && (tss_reg > {1'b0, cfg.inhibit_ticks})) begin
                        applied_next = duty_req;
                        stopped_next = 1'b1;
                    end else begin
                        applied_next = min_now;
                    end
                end else if (stopped_reg) begin
                    kick         = 1'b1;
                    stopped_next = 1'b0;
                    tss_next     = '0;
                    applied_next = fdg_pkg::clamp_duty({1'b0, cfg.start_duty});
                end else begin
                    applied_next = fdg_pkg::clamp_duty({1'b0, duty_req});
                end
            end
            fdg_pkg::OP_TICK: begin
                if (tss_reg != fdg_pkg::COUNT_MAX) tss_next = tss_reg + 1'b1;
                if (tsr_reg != fdg_pkg::COUNT_MAX) tsr_next = tsr_reg + 1'b1;
            end
            fdg_pkg::OP_RAISE: begin
                if (tsr_reg > {1'b0, cfg.adjust_interval}) begin
                    raised      = 1'b1;
                    tsr_next    = '0;
                    offset_next = fdg_pkg::clamp_duty({1'b0, offset_reg}
                                                      + {1'b0, fdg_pkg::RAISE_STEP});
                end
            end
            default: ;
        endcase
    end

    assign res.duty_out      = applied_next;
    assign res.fan_stopped   = stopped_next;
    assign res.effective_min = fdg_pkg::clamp_duty({1'b0, cfg.min_duty} + {1'b0, offset_next});
    assign res.min_raised    = raised;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stopped_reg <= 1'b0;
            applied_reg <= '0;
            tss_reg     <= fdg_pkg::COUNT_MAX;
            tsr_reg     <= fdg_pkg::COUNT_MAX;
            offset_reg  <= '0;
        end else if (step) begin
            stopped_reg <= stopped_next;
            applied_reg <= applied_next;
            tss_reg     <= tss_next;
            tsr_reg     <= tsr_next;
            offset_reg  <= offset_next;
        end
    end

    a_offset_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        offset_reg <= fdg_pkg::DUTY_MAX)
        else $error("min offset above full duty");

    a_applied_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        applied_reg <= fdg_pkg::DUTY_MAX)
        else $error("applied duty above full duty");

    a_raise_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        step && raised |=> tsr_reg == '0)
        else $error("raise did not restart interval counter");

    a_kick_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        step && kick |=> tss_reg == '0 && !stopped_reg)
        else $error("kick-start did not restart inhibit counter");

    a_raise_only_on_adjust: assert property (@(posedge aclk) disable iff (!aresetn)
        raised |-> op == fdg_pkg::OP_RAISE)
        else $error("raise flagged on non-adjust item");

endmodule
`default_nettype wire

FILE: rtl/fan_duty_governor.sv
`default_nettype none
// channel   | dir | handshake          | payload
// ----------+-----+--------------------+---------------------------------------------
// s_        | in  | s_tvalid/s_tready  | tuser: operation; tdata: duty_request
// m_        | out | m_tvalid/m_tready  | tdata: duty_out, fan_stopped, effective_min,
//           |     |                    |        min_raised
// apb       | in  | psel/penable       | 5 registers at byte address 4*index
//
// one beat per cycle sustained while m_tready is high; an input beat goes through the input
// register, then the result register, with the governor logic between them
// state counters and offset update in the cycle the item moves into the result register
// a stalled result register holds its beat; the input register keeps taking beats
// as long as the result register drains or is empty
// reset (synchronous, aresetn low) empties both stages and restores register defaults
module fan_duty_governor (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [6:0] duty_request, [7] zero
    input  wire logic [1:0]  s_tuser,   // [1:0] operation
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [6:0] duty_out, [7] fan_stopped,
                                        // [14:8] effective_min, [15] min_raised
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    fdg_pkg::cfg_t cfg;
    fdg_pkg::res_t res;

    // input stage
    logic                        in_valid_reg;
    logic [fdg_pkg::OP_W-1:0]    in_op_reg;
    logic [fdg_pkg::DUTY_W-1:0]  in_req_reg;

    // result stage
    logic                        out_valid_reg;
    fdg_pkg::res_t               out_res_reg;

    // item moves from input stage into result stage
    logic                        advance;
    logic                        s_beat;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_beat   = s_tvalid && s_tready;

    fdg_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fdg_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .step     (advance),
        .op       (in_op_reg),
        .duty_req (in_req_reg),
        .res      (res)
    );

    // input register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_beat) begin
            in_op_reg  <= s_tuser;
            in_req_reg <= s_tdata[6:0];
        end
    end

    // result register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg;

endmodule
`default_nettype wire
